// ===== sv/ils_pkg.sv =====
// Shared constants, codes and beat types for the indexed list store.
package ils_pkg;

  localparam int CAPACITY     = 64;
  localparam int ELEMENT_BITS = 32;
  localparam int ADDR_W       = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int CALC_W       = ((CNT_W > 8) ? CNT_W : 8) + 2;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_APPEND = 3'd2,
    OP_READ   = 3'd3,
    OP_INSERT = 3'd4,
    OP_REMOVE = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic signed [7:0] position;
    logic [31:0]       element;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [6:0]  count;
  } out_item_t;

  typedef struct packed {
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ELEMENT_BITS-1:0] wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
  } mem_req_t;

endpackage

// ===== sv/indexed_list_store.sv =====
// Sequence after accept: read takes a RAM read and capture, clear and rejected operations go straight to the result;
// push/append/insert shift then fill, pop/remove read, capture and then shift, moving n entries (n <= 63).
// Throughput: one operation at a time; the single RAM port pair moves one entry per cycle,
// so a beat holds the block longest for a pop or remove at the front of a full list.
// Reset: synchronous active-low rst_n empties the list and the output register;
// entry storage is not cleared and is never read before it is written.
module indexed_list_store (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ils_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ils_pkg::out_item_t out_data
);
  import ils_pkg::*;

  logic                    res_valid;
  logic                    res_ready;
  out_item_t               res;
  mem_req_t                mem_req;
  logic [ELEMENT_BITS-1:0] rd_data;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  ils_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_data),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  ils_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Take a result when the output register is empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/ils_ram.sv =====
// Entry storage: one write port and one registered read port.
module ils_ram (
  input  logic                            clk,
  input  ils_pkg::mem_req_t               req,
  output logic [ils_pkg::ELEMENT_BITS-1:0] rd_data
);
  import ils_pkg::*;

  logic [ELEMENT_BITS-1:0] mem_r [CAPACITY];
  logic [ELEMENT_BITS-1:0] rd_data_r;

  // Write and read the array; read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/ils_seq.sv =====
// Operation sequencer: decodes an operation, moves entries one per cycle, builds the result.
module ils_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  ils_pkg::in_item_t                in_item,
  output logic                             in_ready,
  output logic                             res_valid,
  input  logic                             res_ready,
  output ils_pkg::out_item_t               res,
  output ils_pkg::mem_req_t                mem_req,
  input  logic [ils_pkg::ELEMENT_BITS-1:0] rd_data
);
  import ils_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_CAPT  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_FILL  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  localparam logic signed [CALC_W-1:0] ONE_S = CALC_W'(1);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  status_t                 status_r, status_nxt;
  logic [31:0]             value_r, value_nxt;
  logic [ELEMENT_BITS-1:0] elem_r, elem_nxt;
  logic [ADDR_W-1:0]       idx_r, idx_nxt;
  logic                    is_ins_r, is_ins_nxt;
  logic                    is_rmv_r, is_rmv_nxt;
  logic [ADDR_W-1:0]       src_r, src_nxt;
  logic [ADDR_W-1:0]       last_r, last_nxt;
  logic [ADDR_W-1:0]       dst_r, dst_nxt;
  logic                    up_r, up_nxt;
  logic                    src_act_r, src_act_nxt;
  logic                    pend_r, pend_nxt;

  logic signed [CALC_W-1:0] pos_s, len_s, rd_pos, ins_pos;
  logic                     rd_ok, ins_ok, full;
  logic [ADDR_W-1:0]        add_idx, get_idx;
  logic [CNT_W-1:0]         idx_plus1;

  // Decode the position against the current length
  always_comb begin
    pos_s   = signed'({{(CALC_W-8){in_item.position[7]}}, in_item.position});
    len_s   = signed'(CALC_W'(count_r));
    rd_ok   = (pos_s >= -len_s) && (pos_s < len_s);
    ins_ok  = (pos_s >= -len_s - ONE_S) && (pos_s <= len_s);
    rd_pos  = pos_s[CALC_W-1] ? (len_s + pos_s) : pos_s;
    ins_pos = pos_s[CALC_W-1] ? (len_s + pos_s + ONE_S) : pos_s;
    full    = (count_r == CNT_W'(CAPACITY));
    case (in_item.operation)
      OP_PUSH:   add_idx = '0;
      OP_APPEND: add_idx = count_r[ADDR_W-1:0];
      default:   add_idx = ins_pos[ADDR_W-1:0];
    endcase
    get_idx   = (in_item.operation == OP_POP) ? '0 : rd_pos[ADDR_W-1:0];
    idx_plus1 = CNT_W'(idx_r) + CNT_W'(1);
  end

  // Advance the sequencer
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    value_nxt   = value_r;
    elem_nxt    = elem_r;
    idx_nxt     = idx_r;
    is_ins_nxt  = is_ins_r;
    is_rmv_nxt  = is_rmv_r;
    src_nxt     = src_r;
    last_nxt    = last_r;
    dst_nxt     = dst_r;
    up_nxt      = up_r;
    src_act_nxt = src_act_r;
    pend_nxt    = pend_r;
    mem_req     = '0;
    in_ready    = (state_r == S_IDLE);
    res_valid   = (state_r == S_DONE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_OK;
          value_nxt  = '0;
          elem_nxt   = in_item.element[ELEMENT_BITS-1:0];
          is_ins_nxt = 1'b0;
          is_rmv_nxt = 1'b0;
          pend_nxt   = 1'b0;
          state_nxt  = S_DONE;
          case (in_item.operation)
            OP_PUSH, OP_APPEND, OP_INSERT: begin
              if ((in_item.operation == OP_INSERT) && !ins_ok) begin
                status_nxt = ST_INVALID;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                // Open a gap at the target, walking down from the tail
                idx_nxt     = add_idx;
                src_nxt     = ADDR_W'(count_r - CNT_W'(1));
                last_nxt    = add_idx;
                up_nxt      = 1'b0;
                src_act_nxt = (count_r > CNT_W'(add_idx));
                is_ins_nxt  = 1'b1;
                state_nxt   = S_SHIFT;
              end
            end
            OP_POP, OP_READ, OP_REMOVE: begin
              if ((in_item.operation == OP_POP) ? (count_r == '0) : !rd_ok) begin
                status_nxt = ST_INVALID;
              end else begin
                idx_nxt    = get_idx;
                is_rmv_nxt = (in_item.operation != OP_READ);
                state_nxt  = S_READ;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              status_nxt = ST_INVALID;
            end
          endcase
        end
      end

      S_READ: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = idx_r;
        state_nxt       = S_CAPT;
      end

      S_CAPT: begin
        value_nxt = 32'(rd_data);
        if (is_rmv_r) begin
          // Close the gap, walking up from the entry after the target
          src_nxt     = idx_plus1[ADDR_W-1:0];
          last_nxt    = ADDR_W'(count_r - CNT_W'(1));
          up_nxt      = 1'b1;
          src_act_nxt = (idx_plus1 < count_r);
          state_nxt   = S_SHIFT;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SHIFT: begin
        // Drop the previous read into its new slot
        if (pend_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = dst_r;
          mem_req.wr_data = rd_data;
        end
        // Fetch the next source entry
        if (src_act_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = src_r;
          dst_nxt         = up_r ? (src_r - ADDR_W'(1)) : (src_r + ADDR_W'(1));
          src_nxt         = up_r ? (src_r + ADDR_W'(1)) : (src_r - ADDR_W'(1));
          src_act_nxt     = (src_r != last_r);
          pend_nxt        = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (!src_act_r && !pend_r) begin
          if (is_ins_r) begin
            state_nxt = S_FILL;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_DONE;
          end
        end
      end

      S_FILL: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = idx_r;
        mem_req.wr_data = elem_r;
        count_nxt       = count_r + CNT_W'(1);
        state_nxt       = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      src_act_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      src_act_r <= src_act_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // Hold operation payload
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    value_r  <= value_nxt;
    elem_r   <= elem_nxt;
    idx_r    <= idx_nxt;
    is_ins_r <= is_ins_nxt;
    is_rmv_r <= is_rmv_nxt;
    src_r    <= src_nxt;
    last_r   <= last_nxt;
    dst_r    <= dst_nxt;
    up_r     <= up_nxt;
  end

  assign res.status = status_r;
  assign res.value  = value_r;
  assign res.count  = count_r;

`ifndef SYNTH
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r == ST_FULL) |-> count_r == CNT_W'(CAPACITY))
    else $error("full status reported on a list that is not full");

  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r != ST_OK) |-> value_r == '0)
    else $error("nonzero value on a failed operation");

  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> state_r == S_IDLE)
    else $error("sequencer did not return to idle after result handoff");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (state_r == S_SHIFT || state_r == S_FILL))
    else $error("entry write outside shift or fill");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the indexed list store: directed and random list operations.
`timescale 1ns / 100ps

module tb;
  import ils_pkg::*;

  // Operation code outside the defined set; the block must answer it as invalid
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_PRINTED = 40;
  localparam int FINAL_WAIT = 80;

  // Random stimulus modes
  localparam int MODE_GROW = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED = 2;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  // Predicted list contents, front at index 0, and results still owed by the block
  logic [ELEMENT_BITS-1:0] list_words[$];
  out_item_t expected_results[$];

  bit idle_on;
  int mismatch_count;
  int cycle_count;
  int ops_accepted;
  int results_checked;
  int longest_list;
  int full_answers;
  int invalid_answers;

  indexed_list_store dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the predicted list and return the answer it must give
  function automatic out_item_t apply_list_op(in_item_t item);
    out_item_t res;
    int len;
    int pos;
    int idx;
    len = list_words.size();
    pos = $signed(item.position);
    res.status = ST_OK;
    res.value = '0;
    case (item.operation)
      OP_PUSH, OP_APPEND: begin
        if (len >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (item.operation == OP_PUSH) begin
          list_words.push_front(item.element[ELEMENT_BITS-1:0]);
        end else begin
          list_words.push_back(item.element[ELEMENT_BITS-1:0]);
        end
      end
      OP_POP: begin
        if (len == 0) begin
          res.status = ST_INVALID;
        end else begin
          res.value = list_words.pop_front();
        end
      end
      OP_READ, OP_REMOVE: begin
        if (pos < -len || pos > len - 1) begin
          res.status = ST_INVALID;
        end else begin
          idx = (pos < 0) ? len + pos : pos;
          res.value = list_words[idx];
          if (item.operation == OP_REMOVE) list_words.delete(idx);
        end
      end
      OP_INSERT: begin
        if (pos < -len - 1 || pos > len) begin
          res.status = ST_INVALID;
        end else if (len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          idx = (pos < 0) ? len + pos + 1 : pos;
          list_words.insert(idx, item.element[ELEMENT_BITS-1:0]);
        end
      end
      OP_CLEAR: begin
        list_words.delete();
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
    res.count = 7'(list_words.size());
    return res;
  endfunction

  // Print one mismatch line (up to a cap) and count it
  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("%0t ns ERROR: %s", $time, msg);
    mismatch_count++;
  endtask

  // Compare one result beat with the oldest expectation
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: status %0d value %h count %0d",
                                got.status, got.value, got.count));
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      if (want.count > longest_list) longest_list = want.count;
      if (want.status == ST_FULL) full_answers++;
      if (want.status == ST_INVALID) invalid_answers++;
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.value !== want.value)
        report_mismatch($sformatf("value %h, expected %h", got.value, want.value));
      if (got.count !== want.count)
        report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
    end
  endtask

  // Predict on each accepted input beat, check each accepted result beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_list_op(in_data));
        ops_accepted++;
      end
      if (out_valid && out_ready) check_result(out_data);
    end
  end

  // Stall the result side in random bursts while idling is on
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("indexed_list_store: mismatch");
      $finish;
    end
  end

  // Send one operation beat; called at a falling edge, returns at a falling edge
  task automatic send_op(input logic [2:0] op, input int pos, input logic [31:0] elem);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_data.operation = op;
    in_data.position = pos[7:0];
    in_data.element = elem;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_element();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Mostly legal positions, with some just past either end and some anywhere
  function automatic int pick_position(int len, bit for_insert);
    int lo;
    int hi;
    int r;
    lo = for_insert ? -len - 1 : -len;
    hi = for_insert ? len : len - 1;
    r = $urandom_range(0, 19);
    if (r < 14 && hi >= lo) return lo + int'($urandom_range(0, hi - lo));
    if (r < 16) return hi + 1;
    if (r < 18) return lo - 1;
    return int'($urandom_range(0, 255)) - 128;
  endfunction

  // Send one random operation, weighted toward growing or shrinking the list
  task automatic send_random_op(input int mode);
    int r;
    int adds;
    int len;
    len = list_words.size();
    adds = (mode == MODE_GROW) ? 60 : (mode == MODE_SHRINK) ? 23 : 41;
    r = $urandom_range(0, 99);
    if (r < 1) begin
      send_op(OP_UNUSED, pick_position(len, 0), pick_element());
    end else if (r < 2) begin
      send_op(OP_CLEAR, pick_position(len, 0), pick_element());
    end else if (r < 17) begin
      send_op(OP_READ, pick_position(len, 0), pick_element());
    end else if (r < 17 + adds) begin
      case ($urandom_range(0, 2))
        0: send_op(OP_PUSH, int'($urandom_range(0, 255)) - 128, pick_element());
        1: send_op(OP_APPEND, int'($urandom_range(0, 255)) - 128, pick_element());
        default: send_op(OP_INSERT, pick_position(len, 1), pick_element());
      endcase
    end else if ($urandom_range(0, 1) == 0) begin
      send_op(OP_POP, int'($urandom_range(0, 255)) - 128, pick_element());
    end else begin
      send_op(OP_REMOVE, pick_position(len, 0), pick_element());
    end
  endtask

  // Empty list answers, then position bounds on a short list
  task automatic test_empty_and_bounds();
    send_op(OP_POP, 0, pick_element());
    send_op(OP_READ, 0, pick_element());
    send_op(OP_REMOVE, -1, pick_element());
    send_op(OP_INSERT, 1, 32'h1234_5678);
    send_op(OP_INSERT, -2, 32'h1234_5678);
    send_op(OP_INSERT, -1, 32'hFFFF_FFFF);
    send_op(OP_PUSH, 0, 32'h0000_0000);
    send_op(OP_APPEND, 0, 32'h8000_0001);
    send_op(OP_READ, -3, '0);
    send_op(OP_READ, -4, '0);
    send_op(OP_READ, 2, '0);
    send_op(OP_READ, 3, '0);
    send_op(OP_INSERT, 3, 32'h5A5A_A5A5);
    send_op(OP_INSERT, -5, 32'hA5A5_5A5A);
    send_op(OP_INSERT, -7, 32'hDEAD_BEEF);
    send_op(OP_READ, 127, '0);
    send_op(OP_READ, -128, '0);
    send_op(OP_UNUSED, 0, '0);
    send_op(OP_REMOVE, -1, '0);
    send_op(OP_REMOVE, 0, '0);
    send_op(OP_REMOVE, 3, '0);
    send_op(OP_POP, 0, '0);
    send_op(OP_CLEAR, 0, '0);
    send_op(OP_READ, 0, '0);
  endtask

  // Fill to capacity, then every add, bound and removal at the full length
  task automatic test_full_list();
    while (list_words.size() < CAPACITY)
      send_op(OP_INSERT, pick_position(list_words.size(), 1) % (list_words.size() + 1),
              pick_element());
    send_op(OP_PUSH, 0, pick_element());
    send_op(OP_APPEND, 0, pick_element());
    send_op(OP_INSERT, CAPACITY, pick_element());
    send_op(OP_INSERT, -CAPACITY - 1, pick_element());
    send_op(OP_INSERT, 0, pick_element());
    send_op(OP_INSERT, CAPACITY + 1, pick_element());
    send_op(OP_INSERT, -CAPACITY - 2, pick_element());
    send_op(OP_READ, CAPACITY - 1, '0);
    send_op(OP_READ, -CAPACITY, '0);
    send_op(OP_READ, CAPACITY, '0);
    send_op(OP_REMOVE, CAPACITY - 1, '0);
    send_op(OP_INSERT, 0, pick_element());
    send_op(OP_REMOVE, -CAPACITY, '0);
    send_op(OP_PUSH, 0, pick_element());
    send_op(OP_POP, 0, '0);
    send_op(OP_REMOVE, CAPACITY / 2, '0);
    send_op(OP_CLEAR, 0, '0);
  endtask

  // Random operations in blocks that drift the length up and down, with idling
  task automatic test_random_ops(input int num_ops);
    int mode;
    idle_on = 1'b1;
    mode = MODE_GROW;
    for (int i = 0; i < num_ops; i++) begin
      if (i % 60 == 0) mode = $urandom_range(MODE_GROW, MODE_MIXED);
      send_random_op(mode);
    end
  endtask

  // Random operations with both sides always ready
  task automatic test_back_to_back(input int num_ops);
    idle_on = 1'b0;
    for (int i = 0; i < num_ops; i++)
      send_random_op((i / 50) % 3);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idle_on = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    ops_accepted = 0;
    results_checked = 0;
    longest_list = 0;
    full_answers = 0;
    invalid_answers = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_and_bounds();
    test_full_list();
    test_random_ops(1000);
    test_back_to_back(250);

    // Drain outstanding results, then watch for stray beats
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (FINAL_WAIT) @(posedge clk);

    $display("ran %0d list operations, %0d answers checked, %0d mismatches",
             ops_accepted, results_checked, mismatch_count);
    $display("longest list %0d entries, %0d full answers, %0d invalid answers",
             longest_list, full_answers, invalid_answers);
    if (mismatch_count == 0) begin
      $display("indexed_list_store: match");
    end else begin
      $display("indexed_list_store: mismatch");
    end
    $finish;
  end

endmodule
